FILE: src/sdta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sdta_pkg;

  // Number of decimal digits needed for a 32-bit magnitude.
  localparam int unsigned NumDigits  = 10;
  localparam int unsigned ValueBits  = 32;
  localparam int unsigned BcdBits    = 4 * NumDigits;
  // Shift steps done by each conversion stage; ValueBits / StepsPerStage stages.
  localparam int unsigned StepsPerStage = 8;
  localparam int unsigned NumDdStages   = ValueBits / StepsPerStage;

  localparam logic [7:0] AsciiZero  = 8'd48;
  localparam logic [7:0] AsciiMinus = 8'd45;

  // Work word of the shift-and-add-3 conversion: decimal digits on top,
  // the binary bits still to be shifted in below.
  typedef struct packed {
    logic                 neg;
    logic [BcdBits-1:0]   bcd;
    logic [ValueBits-1:0] bin;
  } sdta_work_t;

endpackage

`default_nettype wire

FILE: src/signed_int_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// The first character of a number is offered once its beat has passed the entry register,
// the conversion stages and the serializer. A number of 1 to 11 characters holds the
// character port until its last one is taken; the one-character output sets the rate.
// The conversion pipeline takes a new number every cycle while the output drains, until its stages are full.
// Reset is asynchronous and active low; it empties every stage, no payload is cleared.
module signed_int_to_decimal_ascii_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  character_o,
  output logic        last_char_o
);
  import sdta_pkg::*;

  // Entry stage: sign split and two's complement magnitude. The magnitude is
  // held in 32 unsigned bits, so the most negative value yields 2147483648.
  logic       ent_valid_q;
  sdta_work_t ent_data_q;
  logic       ent_ready;

  logic       dd_valid [NumDdStages+1];
  logic       dd_ready [NumDdStages+1];
  sdta_work_t dd_data  [NumDdStages+1];

  assign ent_ready  = !ent_valid_q || dd_ready[0];
  assign in_ready_o = ent_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= 1'b0;
    end else if (ent_ready) begin
      ent_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_ready && in_valid_i) begin
      ent_data_q.neg <= value_i[ValueBits-1];
      ent_data_q.bcd <= '0;
      ent_data_q.bin <= value_i[ValueBits-1] ? (32'd0 - value_i) : value_i;
    end
  end

  assign dd_valid[0] = ent_valid_q;
  assign dd_data[0]  = ent_data_q;

  // Binary to decimal conversion, eight bits per stage, each stage with its own valid bit.
  for (genvar g = 0; g < NumDdStages; g++) begin : g_dd
    sdta_dd_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (dd_valid[g]),
      .in_ready_o  (dd_ready[g]),
      .in_data_i   (dd_data[g]),
      .out_valid_o (dd_valid[g+1]),
      .out_ready_i (dd_ready[g+1]),
      .out_data_o  (dd_data[g+1])
    );
  end

  // Output serializer. It holds one converted number and walks its digits from
  // the most significant nonzero one down to the units digit, with a pending
  // minus sign sent first. The next number loads as the last beat leaves.
  logic       ser_valid_q;
  logic       ser_minus_q;
  logic [3:0] ser_digit_q [NumDigits];
  logic [3:0] ser_idx_q;
  logic [3:0] top_idx;
  logic       ser_load;
  logic       ser_last;
  sdta_work_t tail;

  assign tail = dd_data[NumDdStages];

  // Highest nonzero digit; zero keeps index 0 so that a single '0' goes out.
  always_comb begin
    top_idx = 4'd0;
    for (int d = 0; d < NumDigits; d++) begin
      if (tail.bcd[4*d +: 4] != 4'd0) begin
        top_idx = 4'(d);
      end
    end
  end

  assign ser_last = !ser_minus_q && (ser_idx_q == 4'd0);
  assign ser_load = !ser_valid_q || (out_ready_i && ser_last);
  assign dd_ready[NumDdStages] = ser_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_valid_q <= 1'b0;
      ser_minus_q <= 1'b0;
      ser_idx_q   <= 4'd0;
    end else if (ser_load) begin
      ser_valid_q <= dd_valid[NumDdStages];
      ser_minus_q <= tail.neg;
      ser_idx_q   <= top_idx;
    end else if (out_ready_i) begin
      if (ser_minus_q) begin
        ser_minus_q <= 1'b0;
      end else begin
        ser_idx_q <= ser_idx_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_load && dd_valid[NumDdStages]) begin
      for (int d = 0; d < NumDigits; d++) begin
        ser_digit_q[d] <= tail.bcd[4*d +: 4];
      end
    end
  end

  assign out_valid_o = ser_valid_q;
  assign character_o = ser_minus_q ? AsciiMinus : (AsciiZero + {4'd0, ser_digit_q[ser_idx_q]});
  assign last_char_o = ser_last;

endmodule

`default_nettype wire

FILE: src/sdta_dd_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module sdta_dd_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sdta_pkg::sdta_work_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sdta_pkg::sdta_work_t out_data_o
);
  import sdta_pkg::*;

  logic       valid_q;
  sdta_work_t data_q;
  sdta_work_t data_d;

  // Eight shift steps; before each shift every digit of five or more gets three added.
  always_comb begin
    data_d = in_data_i;
    for (int s = 0; s < StepsPerStage; s++) begin
      for (int d = 0; d < NumDigits; d++) begin
        if (data_d.bcd[4*d +: 4] >= 4'd5) begin
          data_d.bcd[4*d +: 4] = data_d.bcd[4*d +: 4] + 4'd3;
        end
      end
      {data_d.bcd, data_d.bin} = {data_d.bcd[BcdBits-2:0], data_d.bin, 1'b0};
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

FILE: bench/tb_signed_int_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps

// Bench for the signed integer to decimal ASCII converter. Every number sent in is
// turned into its expected run of characters by a small predictor in this file, and
// every character beat leaving the block is compared against the oldest character
// still owed. Stimulus starts with hand-picked corner values and continues with
// random numbers spread over every text length, under several idling patterns.
module tb_signed_int_to_decimal_ascii_unit;
  import sdta_pkg::*;

  // One character of expected text: the ASCII code and the end-of-number mark.
  typedef struct packed {
    logic [7:0] code;
    logic       last_char;
  } text_char_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [31:0] value_i     = '0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [7:0]  character_o;
  logic        last_char_o;

  // Characters owed by the block, oldest first.
  text_char_t pending_chars[$];
  int         mismatch_count = 0;
  // Percentages of cycles in which the sender holds back and the receiver stalls.
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;

  signed_int_to_decimal_ascii_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .character_o (character_o),
    .last_char_o (last_char_o)
  );

  // 8 ns period, low half first.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Prints one line for a failed comparison and counts it.
  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("ERROR at %0t ns: %s", $time, what);
  endtask

  // Appends the decimal text of one 32-bit two's complement number to the queue of
  // owed characters. The magnitude is taken in 32 unsigned bits, so the most
  // negative number yields 2147483648 without overflow.
  function automatic void queue_decimal_text(input logic [31:0] number);
    logic        negative;
    logic [31:0] magnitude;
    logic [3:0]  digit [10];
    int          num_digits;
    text_char_t  ch;
    negative   = number[31];
    magnitude  = negative ? (32'd0 - number) : number;
    num_digits = 0;
    // Peel digits off the low end; zero still yields one digit.
    do begin
      digit[num_digits] = 4'(magnitude % 32'd10);
      magnitude         = magnitude / 32'd10;
      num_digits++;
    end while (magnitude != 32'd0);
    if (negative) begin
      ch.code      = AsciiMinus;
      ch.last_char = 1'b0;
      pending_chars.push_back(ch);
    end
    for (int k = num_digits - 1; k >= 0; k--) begin
      ch.code      = AsciiZero + 8'(digit[k]);
      ch.last_char = (k == 0);
      pending_chars.push_back(ch);
    end
  endfunction

  // Sampling at the rising edge, where the inputs driven at the falling edge are
  // stable. An accepted number is predicted before the output beat of the same edge
  // is checked, so no latency assumption is built in here.
  always @(posedge clk_i) begin
    text_char_t owed;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        queue_decimal_text(value_i);
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected character beat 0x%02h last %0b",
                                    character_o, last_char_o));
        end else begin
          owed = pending_chars.pop_front();
          if (character_o !== owed.code) begin
            report_mismatch($sformatf("character 0x%02h, wanted 0x%02h",
                                      character_o, owed.code));
          end
          if (last_char_o !== owed.last_char) begin
            report_mismatch($sformatf("last_char %0b on character 0x%02h, wanted %0b",
                                      last_char_o, owed.code, owed.last_char));
          end
        end
      end
    end
  end

  // The receiver decides each cycle, at the falling edge, whether it takes a beat.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Sends one number. Random idle cycles come first; valid then stays high with the
  // value held until the beat is accepted. Valid is left high on return so that a
  // following number can go out back to back.
  task automatic send_value(input logic [31:0] number);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    value_i    <= number;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Lets the sender go quiet and waits for every owed character to come out.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
  endtask

  // Draws a random number. Most draws pick a text length first, so short and long
  // texts are equally common; the rest are raw 32-bit patterns or values right at a
  // power of ten, where the digit count changes.
  function automatic logic [31:0] random_value();
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned magnitude;
    int              num_digits;
    int              pick;
    logic            negative;
    pick       = $urandom_range(0, 99);
    negative   = 1'($urandom_range(0, 1));
    num_digits = $urandom_range(1, 10);
    if (pick < 25) begin
      return $urandom();
    end
    if (pick < 40) begin
      // One below, at or one above a power of ten.
      magnitude = 64'd1;
      for (int k = 1; k < num_digits; k++) magnitude = magnitude * 64'd10;
      magnitude = magnitude + 64'($urandom_range(0, 2)) - 64'd1;
    end else begin
      lo = 64'd1;
      for (int k = 1; k < num_digits; k++) lo = lo * 64'd10;
      hi = lo * 64'd10 - 64'd1;
      if (num_digits == 1) lo = 64'd0;
      if (num_digits == 10) hi = negative ? 64'd2147483648 : 64'd2147483647;
      magnitude = lo + (64'($urandom()) % (hi - lo + 64'd1));
    end
    return negative ? 32'(64'd0 - magnitude) : 32'(magnitude);
  endfunction

  task automatic run_random_values(input int count);
    repeat (count) send_value(random_value());
  endtask

  // Corner values: zero, single digits, both ends of the range, the most negative
  // number with its eleven characters, digit-count boundaries and alternating bits.
  task automatic test_corner_values();
    logic [31:0] corners [] = '{
      32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
      32'd999999999, 32'd1000000000, -32'sd1000000000, -32'sd999999999,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA,
      32'd1234567890, -32'sd123456789
    };
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (corners[i]) send_value(corners[i]);
    wait_drained();
  endtask

  // Numbers offered every cycle and characters taken every cycle.
  task automatic test_back_to_back();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_values(70);
    wait_drained();
  endtask

  // Numbers trickle in, so the block often runs empty between them.
  task automatic test_sparse_input();
    send_idle_pct  = 83;
    recv_stall_pct = 0;
    run_random_values(75);
    wait_drained();
  endtask

  // The receiver stalls most cycles, so characters back up into the pipeline.
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 83;
    run_random_values(75);
    wait_drained();
  endtask

  // Both sides pause at random at the same time.
  task automatic test_mixed_idling();
    send_idle_pct  = 31;
    recv_stall_pct = 31;
    run_random_values(70);
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_corner_values();
    test_back_to_back();
    test_sparse_input();
    test_output_backpressure();
    test_mixed_idling();
    // Wait on after the last drain to catch any stray beat.
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS signed_int_to_decimal_ascii_unit");
    end else begin
      $display("FAIL signed_int_to_decimal_ascii_unit");
    end
    $finish;
  end

  // Far beyond the slowest correct run, even with every character stalled at length.
  initial begin
    #3_000_000;
    $display("FAIL signed_int_to_decimal_ascii_unit");
    $finish;
  end

endmodule
